>>> rtl/fixed_partition_fit_allocator_top_defines.svh
// assertion macros for the checker file
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define FPFA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication, disabled while reset is high
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

>>> rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// shared constants, codes and controller/datapath types of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_WIDTH = 32;

   // fixed field widths
   localparam int MODE_W      = 2;
   localparam int BLK_IDX_W   = 4;
   localparam int POLICY_W    = 2;
   localparam int BCOUNT_W    = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;

   // derived from the table depth
   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   // input modes
   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

   // fit policies, the unused code acts as first-fit
   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIRST;
   localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             clear;
      logic             capture;
      logic             step;
      logic             report;
      logic [IDX_W-1:0] scan_idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] limit;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/fpfa_datapath.sv
// ----------------------------------------------------------------------------
// fpfa_datapath
// block table, taken marks, config registers, candidate compare and result
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  fpfa_pkg::ctrl_cmd_type                    cmd,
   output fpfa_pkg::dp_status_type                   status,
   input  logic [fpfa_pkg::BLK_IDX_W-1:0]            req_block_index,
   input  logic [fpfa_pkg::SIZE_WIDTH-1:0]           req_size,
   input  logic                                      csr_we,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]           csr_wdata,
   output logic                                      rsp_valid,
   output logic                                      rsp_granted,
   output logic [fpfa_pkg::BLK_IDX_W-1:0]            rsp_chosen_block,
   output logic [fpfa_pkg::SIZE_WIDTH-1:0]           rsp_chosen_size
);

   import fpfa_pkg::*;

   logic [SIZE_WIDTH-1:0] sizes_ff [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] size_valid_ff;
   logic [NUM_BLOCKS-1:0] taken_ff;
   logic [NUM_BLOCKS-1:0] taken_in;

   logic [POLICY_W-1:0]   policy_ff;
   logic [BCOUNT_W-1:0]   bcount_ff;

   logic [SIZE_WIDTH-1:0] want_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      pick_ff;
   logic [SIZE_WIDTH-1:0] pick_size_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_granted_ff;
   logic [BLK_IDX_W-1:0]  rsp_block_ff;
   logic [SIZE_WIDTH-1:0] rsp_size_ff;

   logic [SIZE_WIDTH-1:0] cand_size;
   logic                  eligible;
   logic                  better;
   logic [IDX_W-1:0]      load_idx;

   assign load_idx = IDX_W'(req_block_index);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RESET;
         bcount_ff <= BCOUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIT_POLICY:  policy_ff <= csr_wdata[POLICY_W-1:0];
            CSR_BLOCK_COUNT: bcount_ff <= csr_wdata[BCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // counts above the table depth clamp to it
   always_comb begin
      if (int'(bcount_ff) > NUM_BLOCKS) begin
         status.limit = CNT_W'(NUM_BLOCKS);
      end else begin
         status.limit = CNT_W'(bcount_ff);
      end
   end

   // size table, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (cmd.load && (int'(req_block_index) < NUM_BLOCKS)) begin
         sizes_ff[load_idx] <= req_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_valid_ff <= '0;
      end else if (cmd.load && (int'(req_block_index) < NUM_BLOCKS)) begin
         size_valid_ff[load_idx] <= 1'b1;
      end
   end

   // candidate check for the block under the scan pointer
   always_comb begin
      cand_size = size_valid_ff[cmd.scan_idx] ? sizes_ff[cmd.scan_idx] : '0;
      eligible  = !taken_ff[cmd.scan_idx] && (cand_size >= want_ff);
      case (policy_ff)
         POL_BEST:  better = !found_ff || (cand_size < pick_size_ff);
         POL_WORST: better = !found_ff || (cand_size > pick_size_ff);
         default:   better = !found_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         want_ff      <= req_size;
         found_ff     <= 1'b0;
         pick_ff      <= '0;
         pick_size_ff <= '0;
      end else if (cmd.step && eligible && better) begin
         found_ff     <= 1'b1;
         pick_ff      <= cmd.scan_idx;
         pick_size_ff <= cand_size;
      end
   end

   // taken marks
   always_comb begin
      taken_in = taken_ff;
      if (cmd.clear) begin
         taken_in = '0;
      end else if (cmd.report && found_ff) begin
         taken_in[pick_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
      end else begin
         taken_ff <= taken_in;
      end
   end

   // result register, one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.report;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_granted_ff <= found_ff;
         rsp_block_ff   <= found_ff ? BLK_IDX_W'(pick_ff) : '0;
         rsp_size_ff    <= found_ff ? pick_size_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_block_ff;
   assign rsp_chosen_size  = rsp_size_ff;

endmodule

`default_nettype wire

>>> rtl/fpfa_ctrl.sv
// ----------------------------------------------------------------------------
// fpfa_ctrl
// sequencer: decodes the input mode and walks the scan over the blocks
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fpfa_pkg::MODE_W-1:0]   req_mode,
   input  fpfa_pkg::dp_status_type       status,
   output fpfa_pkg::ctrl_cmd_type        cmd,
   output logic                          busy
);

   import fpfa_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic [CNT_W-1:0] idx_next;
   logic             accept;

   assign accept   = start && (state_ff == ST_IDLE);
   assign idx_next = CNT_W'(idx_ff + 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept && (req_mode == MODE_REQUEST)) begin
               state_in = (status.limit == '0) ? ST_REPORT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_next;
            if (idx_next == status.limit) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.scan_idx = idx_ff[IDX_W-1:0];
      busy         = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               unique case (req_mode)
                  MODE_LOAD:    cmd.load    = 1'b1;
                  MODE_REQUEST: cmd.capture = 1'b1;
                  MODE_CLEAR:   cmd.clear   = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN:   cmd.step   = 1'b1;
         ST_REPORT: cmd.report = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fixed_partition_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_top
// fixed-partition allocator with first, best and worst fit
// ----------------------------------------------------------------------------
// usage
//   input: an item transfers on a rising edge with start high and busy low.
//   req_mode picks load (write req_size into block req_block_index), clear
//   (drop every taken mark) or request (allocate a block of req_size or more).
//   load and clear finish at the accepting edge; busy stays low, no result.
//   a request raises busy while the sequencer checks one block per cycle
//   over the lowest min(block_count, 16) blocks, then a report state commits
//   the pick; the result strobes on rsp_valid for one cycle after that.
//   the next item may transfer in the result cycle itself.
//   results: rsp_valid marks the one cycle a result transfers; the receiver
//   cannot stall it, so it must take every strobe.
//   config: csr_we writes csr_wdata to register csr_index (0 fit_policy,
//   1 block_count); write only while idle.
//   reset: synchronous, active high; sizes read as zero, no block is
//   taken, policy first-fit, sixteen blocks in use.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator_top (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                start,
   output logic                                busy,
   input  logic [fpfa_pkg::MODE_W-1:0]         req_mode,
   input  logic [fpfa_pkg::BLK_IDX_W-1:0]      req_block_index,
   input  logic [fpfa_pkg::SIZE_WIDTH-1:0]     req_size,
   // results
   output logic                                rsp_valid,
   output logic                                rsp_granted,
   output logic [fpfa_pkg::BLK_IDX_W-1:0]      rsp_chosen_block,
   output logic [fpfa_pkg::SIZE_WIDTH-1:0]     rsp_chosen_size,
   // configuration writes
   input  logic                                csr_we,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import fpfa_pkg::*;

   // sequencer commands and datapath status
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // mode decode, scan pointer, busy
   fpfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // table, marks, config registers and result register
   fpfa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_block_index  (req_block_index),
      .req_size         (req_size),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_chosen_size  (rsp_chosen_size)
   );

endmodule

`default_nettype wire

>>> rtl/fpfa_checker.sv
// ----------------------------------------------------------------------------
// fpfa_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_partition_fit_allocator_top_defines.svh"

module fpfa_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [fpfa_pkg::MODE_W-1:0]         req_mode,
   input  logic                                rsp_valid,
   input  logic                                rsp_granted,
   input  logic [fpfa_pkg::BLK_IDX_W-1:0]      rsp_chosen_block,
   input  logic [fpfa_pkg::SIZE_WIDTH-1:0]     rsp_chosen_size
);

   import fpfa_pkg::*;

   logic req_xfer;
   logic quick_xfer;
   logic rsp_zero;

   assign req_xfer   = start && !busy && (req_mode == MODE_REQUEST);
   assign quick_xfer = start && !busy &&
                       ((req_mode == MODE_LOAD) || (req_mode == MODE_CLEAR));
   assign rsp_zero   = (rsp_chosen_block == '0) && (rsp_chosen_size == '0);

   // a denied request reports block and size as zero
   `FPFA_ASSERT_SAME(a_deny_zero, clock, reset, rsp_valid && !rsp_granted, rsp_zero)
   // an accepted request keeps the block busy
   `FPFA_ASSERT_NEXT(a_req_busy, clock, reset, req_xfer, busy)
   // load and clear finish at once with no result
   `FPFA_ASSERT_NEXT(a_quick_done, clock, reset, quick_xfer, !busy && !rsp_valid)
   // a result comes with the block idle again
   `FPFA_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // one strobe per request
   `FPFA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

endmodule

bind fixed_partition_fit_allocator_top fpfa_checker u_fpfa_checker (.*);

`default_nettype wire

>>> dv/fixed_partition_fit_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_top_tb
// self-checking bench for the fixed-partition allocator: a queue-fed driver
// sends load, clear and request transfers, a clocked monitor keeps its own
// copy of the block table and checks every result against it, and register
// writes between phases walk through every fit policy and through block counts
// from zero to beyond the table depth

module fixed_partition_fit_allocator_top_tb;
   import fpfa_pkg::*;

   // codes the package leaves unnamed
   localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;
   localparam logic [POLICY_W-1:0] POL_SPARE  = 2'd3;

   // margins that cover the longest request
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES   = 40;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_ITEMS   = 130;
   localparam int PRINT_CAP     = 200;

   typedef struct {
      logic [MODE_W-1:0]     mode;
      logic [BLK_IDX_W-1:0]  block_index;
      logic [SIZE_WIDTH-1:0] size;
      bit                    drain_first;   // wait for all results before sending
   } alloc_item_type;

   typedef struct packed {
      logic                  granted;
      logic [BLK_IDX_W-1:0]  block;
      logic [SIZE_WIDTH-1:0] size;
   } grant_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [MODE_W-1:0]       req_mode = MODE_LOAD;
   logic [BLK_IDX_W-1:0]    req_block_index = '0;
   logic [SIZE_WIDTH-1:0]   req_size = '0;
   logic                    rsp_valid;
   logic                    rsp_granted;
   logic [BLK_IDX_W-1:0]    rsp_chosen_block;
   logic [SIZE_WIDTH-1:0]   rsp_chosen_size;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_FIT_POLICY;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   fixed_partition_fit_allocator_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_block_index  (req_block_index),
      .req_size         (req_size),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_chosen_size  (rsp_chosen_size),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // shared state
   // ------------------------------------------------------------------
   alloc_item_type        pending_items[$];     // filled by the stimulus block
   grant_type             expected_grants[$];   // oldest first
   bit                    item_taken = 1'b0;    // transfer seen at the last rising edge
   bit                    quiet_tail = 1'b0;    // no sender gaps in the last phase
   int                    gap_left = 0;

   // allocator image kept by the monitor
   logic [SIZE_WIDTH-1:0] block_size [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] block_taken;
   logic [POLICY_W-1:0]   fit_sel;
   logic [BCOUNT_W-1:0]   blocks_in_use;

   // sizes the stimulus has loaded so far, used to aim requests at them
   logic [SIZE_WIDTH-1:0] plan_size [NUM_BLOCKS];

   int mismatches = 0;
   int stim_count = 0;
   int n_load = 0, n_clear = 0, n_req = 0, n_grant = 0, n_spare = 0;
   int n_checked = 0, n_csr = 0;

   task automatic flag_mismatch(input string what);
      mismatches++;
      // keep the log bounded when something is badly off
      if (mismatches <= PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, what);
   endtask

   // scan the blocks in use, pick by policy, mark the pick taken
   function automatic grant_type fit_pick(input logic [SIZE_WIDTH-1:0] want);
      grant_type pick;
      int        limit;
      logic      better;
      pick  = '0;
      limit = (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_in_use);
      for (int j = 0; j < limit; j++) begin
         if (!block_taken[j] && block_size[j] >= want) begin
            if (!pick.granted)
               better = 1'b1;
            else if (fit_sel == POL_BEST)
               better = block_size[j] < pick.size;
            else if (fit_sel == POL_WORST)
               better = block_size[j] > pick.size;
            else
               better = 1'b0;   // first-fit, spare code included
            if (better) begin
               pick.granted = 1'b1;
               pick.block   = BLK_IDX_W'(j);
               pick.size    = block_size[j];
            end
         end
      end
      if (pick.granted)
         block_taken[pick.block] = 1'b1;
      return pick;
   endfunction

   // ------------------------------------------------------------------
   // driver: one item per transfer, random gaps after some transfers
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      alloc_item_type nxt;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else if (start && !item_taken) begin
         // block is busy, hold the item
      end else if (gap_left > 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain_first && expected_grants.size() != 0)) begin
         nxt = pending_items.pop_front();
         start           <= 1'b1;
         req_mode        <= nxt.mode;
         req_block_index <= nxt.block_index;
         req_size        <= nxt.size;
         if (!quiet_tail && $urandom_range(0, 5) == 0)
            gap_left <= $urandom_range(1, 16);
      end else begin
         start <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // monitor: check results first, then predict the newly accepted item
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      grant_type want;
      if (reset) begin
         item_taken    <= 1'b0;
         block_taken   = '0;
         fit_sel       = POLICY_RESET;
         blocks_in_use = BCOUNT_RESET;
         for (int j = 0; j < NUM_BLOCKS; j++)
            block_size[j] = '0;
      end else begin
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               flag_mismatch($sformatf("result with nothing pending, block %0d size %h",
                                       rsp_chosen_block, rsp_chosen_size));
            end else begin
               want = expected_grants.pop_front();
               n_checked++;
               if (rsp_granted !== want.granted)
                  flag_mismatch($sformatf("result %0d granted %b, expected %b",
                                          n_checked, rsp_granted, want.granted));
               if (rsp_chosen_block !== want.block)
                  flag_mismatch($sformatf("result %0d chosen_block %0d, expected %0d",
                                          n_checked, rsp_chosen_block, want.block));
               if (rsp_chosen_size !== want.size)
                  flag_mismatch($sformatf("result %0d chosen_size %h, expected %h",
                                          n_checked, rsp_chosen_size, want.size));
            end
         end

         // next item may transfer in the result cycle itself
         item_taken <= start && !busy;
         if (start && !busy) begin
            case (req_mode)
               MODE_LOAD: begin
                  block_size[req_block_index] = req_size;
                  n_load++;
               end
               MODE_CLEAR: begin
                  block_taken = '0;
                  n_clear++;
               end
               MODE_REQUEST: begin
                  want = fit_pick(req_size);
                  expected_grants.push_back(want);
                  n_req++;
                  if (want.granted)
                     n_grant++;
               end
               default: n_spare++;
            endcase
         end

         if (csr_we) begin
            n_csr++;
            case (csr_index)
               CSR_FIT_POLICY:  fit_sel       = csr_wdata[POLICY_W-1:0];
               CSR_BLOCK_COUNT: blocks_in_use = csr_wdata[BCOUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_item(input logic [MODE_W-1:0] mode, input logic [BLK_IDX_W-1:0] blk,
                           input logic [SIZE_WIDTH-1:0] sz, input bit drain_first);
      alloc_item_type it;
      it.mode        = mode;
      it.block_index = blk;
      it.size        = sz;
      it.drain_first = drain_first;
      pending_items.push_back(it);
      if (mode != MODE_SPARE)
         stim_count++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // all items sent, all results in, and the block given time to go quiet
   task automatic settle();
      while (pending_items.size() != 0 || start || expected_grants.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // small sizes make ties and near misses common, the rest toggle every bit
   function automatic logic [SIZE_WIDTH-1:0] load_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return $urandom_range(1, 48);
      endcase
   endfunction

   function automatic logic [SIZE_WIDTH-1:0] request_size();
      logic [SIZE_WIDTH-1:0] base;
      base = plan_size[$urandom_range(0, NUM_BLOCKS - 1)];
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return $urandom;
         2:       return base + 1;
         3:       return base - 1;
         4:       return $urandom_range(1, 48);
         default: return base;
      endcase
   endfunction

   // clear (mostly), a few loads, then a run of requests
   task automatic queue_round(input bit drain_first);
      bit                    hold;
      logic [BLK_IDX_W-1:0]  blk;
      logic [SIZE_WIDTH-1:0] sz;
      hold = drain_first;
      if ($urandom_range(0, 3) != 0) begin
         add_item(MODE_CLEAR, BLK_IDX_W'($urandom), $urandom, hold);
         hold = 1'b0;
      end
      repeat ($urandom_range(0, 5)) begin
         blk = BLK_IDX_W'($urandom);
         sz  = load_size();
         plan_size[blk] = sz;
         add_item(MODE_LOAD, blk, sz, hold);
         hold = 1'b0;
      end
      repeat ($urandom_range(1, 8)) begin
         add_item(MODE_REQUEST, BLK_IDX_W'($urandom), request_size(), hold);
         hold = 1'b0;
         // stray item of the unused mode now and then
         if ($urandom_range(0, 15) == 0)
            add_item(MODE_SPARE, BLK_IDX_W'($urandom), $urandom, 1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // stimulus: directed phases, random phases, quiet tail
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] pol_word;
      logic [CSR_DATA_W-1:0] cnt_word;
      int                    goal;

      for (int j = 0; j < NUM_BLOCKS; j++)
         plan_size[j] = '0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset state: first-fit over all blocks, every size zero
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);            // zero-size block fits zero
      add_item(MODE_REQUEST, 4'd0, 32'd1, 1'b0);         // nothing fits
      add_item(MODE_LOAD, 4'd0, '1, 1'b0);
      add_item(MODE_LOAD, 4'd15, '1, 1'b0);
      add_item(MODE_LOAD, 4'd7, 32'h8000_0000, 1'b0);
      add_item(MODE_LOAD, 4'd3, 32'h0000_0040, 1'b0);
      add_item(MODE_SPARE, 4'd15, '1, 1'b0);             // unused mode, no effect
      add_item(MODE_REQUEST, 4'd0, '1, 1'b0);            // largest size, block 0 taken
      add_item(MODE_CLEAR, 4'd5, 32'h5555_5555, 1'b1);   // sender waits for the drain
      add_item(MODE_REQUEST, 4'd10, '1, 1'b0);
      settle();

      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(POL_BEST));
      add_item(MODE_REQUEST, 4'd0, 32'h41, 1'b0);
      add_item(MODE_REQUEST, 4'd0, 32'h1, 1'b0);
      settle();

      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(POL_WORST));
      add_item(MODE_CLEAR, 4'd0, '0, 1'b0);
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);            // tie between the two largest
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);
      settle();

      // spare policy code acts as first-fit
      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(POL_SPARE));
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);
      settle();

      // no block in use
      write_reg(CSR_BLOCK_COUNT, '0);
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);
      settle();

      // count above the table depth saturates
      write_reg(CSR_BLOCK_COUNT, '1);
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);
      settle();

      // one block in use, load lands in an unused block
      write_reg(CSR_BLOCK_COUNT, CSR_DATA_W'(1));
      add_item(MODE_LOAD, 4'd12, 32'h1234_5678, 1'b0);
      add_item(MODE_CLEAR, 4'd0, '0, 1'b0);
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);
      add_item(MODE_REQUEST, 4'd0, '0, 1'b0);
      settle();
      plan_size[0]  = '1;
      plan_size[15] = '1;
      plan_size[7]  = 32'h8000_0000;
      plan_size[3]  = 32'h0000_0040;
      plan_size[12] = 32'h1234_5678;

      // the stored block joins once the count covers it
      write_reg(CSR_BLOCK_COUNT, CSR_DATA_W'(NUM_BLOCKS));
      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(POL_BEST));
      add_item(MODE_REQUEST, 4'd0, 32'h1234_5678, 1'b0);
      settle();

      // random phases, each with its own policy and block count
      goal = stim_count;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pol_word = CSR_DATA_W'($urandom);          // upper bits ignored by the block
         pol_word[POLICY_W-1:0] = POLICY_W'(p % 4);
         case (p % 6)
            0, 2:    cnt_word = CSR_DATA_W'(NUM_BLOCKS);
            1:       cnt_word = CSR_DATA_W'($urandom_range(2, NUM_BLOCKS - 1));
            3:       cnt_word = CSR_DATA_W'($urandom_range(NUM_BLOCKS + 1, 31));
            4:       cnt_word = CSR_DATA_W'(1);
            default: cnt_word = '0;
         endcase
         write_reg(CSR_FIT_POLICY, pol_word);
         write_reg(CSR_BLOCK_COUNT, cnt_word);
         goal += (cnt_word == 0) ? 30 : PHASE_ITEMS;
         queue_round(1'b1);                          // every phase opens drained
         while (stim_count < goal)
            queue_round($urandom_range(0, 19) == 0);
         settle();
      end

      // last phase runs without any sender gaps
      quiet_tail = 1'b1;
      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(POL_WORST));
      write_reg(CSR_BLOCK_COUNT, CSR_DATA_W'(NUM_BLOCKS));
      goal += PHASE_ITEMS;
      while (stim_count < goal)
         queue_round(1'b0);

      while (pending_items.size() != 0 || start || expected_grants.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d transfers: %0d loads, %0d clears, %0d requests %s",
               n_load + n_clear + n_req + n_spare, n_load, n_clear, n_req,
               $sformatf("(%0d granted), %0d ignored", n_grant, n_spare));
      $display("%0d register writes, %0d results checked, %0d mismatches",
               n_csr, n_checked, mismatches);
      if (mismatches == 0)
         $display("fixed_partition_fit_allocator_top_tb OK");
      else
         $display("fixed_partition_fit_allocator_top_tb NOT OK");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #5_000_000;
      $display("timeout with %0d results still pending", expected_grants.size());
      $display("fixed_partition_fit_allocator_top_tb NOT OK");
      $finish;
   end

endmodule
